FILE: hdl/bale_pkg.sv
// ============================================================================
// bale_pkg : shared types and constants for the bounded array list engine
// Command and status codes, storage sizes and the input and result words.
// ============================================================================
package bale_pkg;

  // Number of elements the list can hold.
  localparam int CAPACITY = 16;
  // Index into the element store.
  localparam int IDX_W    = $clog2(CAPACITY);
  // Width of counts, positions and slots, as fixed by the word fields.
  localparam int CNT_W    = 5;
  localparam int DATA_W   = 32;

  // Command codes.
  localparam logic [3:0] CMD_CLEAR     = 4'd0;
  localparam logic [3:0] CMD_INS_FRONT = 4'd1;
  localparam logic [3:0] CMD_INS_BACK  = 4'd2;
  localparam logic [3:0] CMD_RM_FRONT  = 4'd3;
  localparam logic [3:0] CMD_RM_BACK   = 4'd4;
  localparam logic [3:0] CMD_RM_AT     = 4'd5;
  localparam logic [3:0] CMD_FIND      = 4'd6;
  localparam logic [3:0] CMD_REPLACE   = 4'd7;
  localparam logic [3:0] CMD_RM_VALUE  = 4'd8;
  localparam logic [3:0] CMD_DUMP      = 4'd9;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADPOS   = 3'd4;

  typedef struct packed {
    logic        [3:0]        command;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
    logic        [CNT_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic        [2:0]        status;
    logic        [CNT_W-1:0]  slot;
    logic signed [DATA_W-1:0] item;
    logic        [CNT_W-1:0]  fill;
    logic                     final_res;
  } out_word_t;

endpackage

FILE: hdl/bounded_array_list_engine_core.sv
// ============================================================================
// bounded_array_list_engine_core : fixed-capacity ordered list engine
// Holds up to CAPACITY signed words packed in order and runs list commands
// through a small sequencer around one element store and one comparator.
// ============================================================================
// A user sends one command word at a time; in_stall stays high from the cycle
// after acceptance until the command has finished. Commands that touch only
// the ends (clear, insert at the back, remove from the back) and every
// command that fails its empty, full or position check end in the decode
// state after acceptance. Commands that move or inspect elements (insert
// at the front, remove at the front or at a position, find, replace, remove
// by value, dump) go on to walk the elements concerned and then close. The
// element store has a single registered read port, so the sequencer reads
// one element per cycle while the result register can take a word, and the
// shared comparator and the single write port process the element read in
// the previous active cycle. After the decode state the walk reads each
// element, finishes the last element read, sees that the walk is over, and
// passes to a closing state that updates the fill count and gives the last
// result word, except for a dump, which has already given it. Find and dump
// can give several result words; whenever the result register is full and
// stalled the sequencer pauses in place. The last result word of every
// command carries final_res. Unknown command codes are dropped without a
// result. There is no clearing pass after reset: only positions below the
// fill count are ever read.
module bounded_array_list_engine_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bale_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bale_pkg::out_word_t  out_data
);

  localparam int IW = bale_pkg::IDX_W;
  localparam int CW = bale_pkg::CNT_W;
  localparam int DW = bale_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_FIN
  } state_t;

  // Sequencer state.
  state_t              state_r, state_nxt;
  bale_pkg::in_word_t  cmd_r, cmd_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;

  // Walk control: rd_idx_r is the next element to read, rd_left_r the number
  // of reads still to issue. pend_r marks that rdata_r holds element
  // pend_idx_r, read in the previous active cycle.
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]       rd_left_r, rd_left_nxt;
  logic                pend_r, pend_nxt;
  logic [IW-1:0]       pend_idx_r, pend_idx_nxt;
  logic                down_r, down_nxt;

  // A match seen so far, and the slot of the match held back for find or
  // the copy removed by remove-by-value.
  logic                hit_r, hit_nxt;
  logic [CW-1:0]       hit_slot_r, hit_slot_nxt;

  // Result register.
  logic                out_valid_r;
  bale_pkg::out_word_t out_data_r;

  // Element store.
  logic [DW-1:0]       mem [bale_pkg::CAPACITY];
  logic [DW-1:0]       rdata_r;
  logic                rd_en;
  logic                we;
  logic [IW-1:0]       waddr;
  logic [DW-1:0]       wdata;

  // Result emission from the sequencer.
  logic                emit;
  logic [2:0]          emit_st;
  logic [CW-1:0]       emit_slot;
  logic [DW-1:0]       emit_item;
  logic                emit_last;

  logic                out_free;
  logic                eq;
  logic [CW-1:0]       pend_slot;

  // Beyond the idle state, the sequencer only advances when the result register can take a word.
  assign out_free  = !out_valid_r || !out_stall;
  assign eq        = (rdata_r == cmd_r.value);
  assign pend_slot = CW'(pend_idx_r) + CW'(1);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    occ_nxt      = occ_r;
    rd_idx_nxt   = rd_idx_r;
    rd_left_nxt  = rd_left_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    down_nxt     = down_r;
    hit_nxt      = hit_r;
    hit_slot_nxt = hit_slot_r;
    rd_en        = 1'b0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = rdata_r;
    emit         = 1'b0;
    emit_st      = bale_pkg::ST_OK;
    emit_slot    = '0;
    emit_item    = cmd_r.value;
    emit_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        if (out_free) begin
          state_nxt   = S_IDLE;
          pend_nxt    = 1'b0;
          hit_nxt     = 1'b0;
          down_nxt    = 1'b0;
          rd_idx_nxt  = '0;
          rd_left_nxt = occ_r;
          case (cmd_r.command)
            bale_pkg::CMD_CLEAR: begin
              occ_nxt = '0;
              emit    = 1'b1;
            end
            bale_pkg::CMD_INS_BACK: begin
              emit = 1'b1;
              if (occ_r >= CW'(bale_pkg::CAPACITY)) begin
                emit_st = bale_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = occ_r[IW-1:0];
                wdata   = cmd_r.value;
                occ_nxt = occ_r + CW'(1);
              end
            end
            bale_pkg::CMD_RM_BACK: begin
              emit = 1'b1;
              if (occ_r == '0) begin
                emit_st = bale_pkg::ST_EMPTY;
              end else begin
                occ_nxt = occ_r - CW'(1);
              end
            end
            bale_pkg::CMD_INS_FRONT: begin
              if (occ_r >= CW'(bale_pkg::CAPACITY)) begin
                emit    = 1'b1;
                emit_st = bale_pkg::ST_FULL;
              end else begin
                // Shift every element up by one, walking from the back.
                state_nxt  = S_WALK;
                down_nxt   = 1'b1;
                rd_idx_nxt = IW'(occ_r - CW'(1));
              end
            end
            bale_pkg::CMD_RM_FRONT: begin
              if (occ_r == '0) begin
                emit    = 1'b1;
                emit_st = bale_pkg::ST_EMPTY;
              end else begin
                state_nxt   = S_WALK;
                rd_idx_nxt  = IW'(1);
                rd_left_nxt = occ_r - CW'(1);
              end
            end
            bale_pkg::CMD_RM_AT: begin
              if (occ_r == '0) begin
                emit    = 1'b1;
                emit_st = bale_pkg::ST_EMPTY;
              end else if (cmd_r.position == '0 || cmd_r.position > occ_r) begin
                emit    = 1'b1;
                emit_st = bale_pkg::ST_BADPOS;
              end else begin
                // Elements behind the removed one each move down by one.
                state_nxt   = S_WALK;
                rd_idx_nxt  = IW'(cmd_r.position);
                rd_left_nxt = occ_r - cmd_r.position;
              end
            end
            bale_pkg::CMD_FIND,
            bale_pkg::CMD_DUMP: begin
              if (occ_r == '0) begin
                emit    = 1'b1;
                emit_st = bale_pkg::ST_EMPTY;
                if (cmd_r.command == bale_pkg::CMD_DUMP) begin
                  emit_item = '0;
                end
              end else begin
                state_nxt = S_WALK;
              end
            end
            bale_pkg::CMD_REPLACE,
            bale_pkg::CMD_RM_VALUE: begin
              // An empty list walks nothing and ends as not found.
              state_nxt = S_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        if (out_free) begin
          if (rd_left_r != '0) begin
            rd_en        = 1'b1;
            pend_nxt     = 1'b1;
            pend_idx_nxt = rd_idx_r;
            rd_idx_nxt   = down_r ? (rd_idx_r - IW'(1)) : (rd_idx_r + IW'(1));
            rd_left_nxt  = rd_left_r - CW'(1);
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              state_nxt = S_FIN;
            end
          end

          if (pend_r) begin
            case (cmd_r.command)
              bale_pkg::CMD_INS_FRONT: begin
                we    = 1'b1;
                waddr = pend_idx_r + IW'(1);
              end
              bale_pkg::CMD_RM_FRONT,
              bale_pkg::CMD_RM_AT: begin
                we    = 1'b1;
                waddr = pend_idx_r - IW'(1);
              end
              bale_pkg::CMD_FIND: begin
                // A match is held back until the next one or the end of the
                // walk shows whether it is the last.
                if (eq) begin
                  if (hit_r) begin
                    emit      = 1'b1;
                    emit_slot = hit_slot_r;
                    emit_last = 1'b0;
                  end
                  hit_nxt      = 1'b1;
                  hit_slot_nxt = pend_slot;
                end
              end
              bale_pkg::CMD_REPLACE: begin
                if (eq) begin
                  we      = 1'b1;
                  waddr   = pend_idx_r;
                  wdata   = cmd_r.new_value;
                  hit_nxt = 1'b1;
                end
              end
              bale_pkg::CMD_RM_VALUE: begin
                // Once the first copy is found, the rest of the walk closes
                // the gap it leaves.
                if (hit_r) begin
                  we    = 1'b1;
                  waddr = pend_idx_r - IW'(1);
                end else if (eq) begin
                  hit_nxt      = 1'b1;
                  hit_slot_nxt = pend_slot;
                end
              end
              bale_pkg::CMD_DUMP: begin
                emit      = 1'b1;
                emit_slot = pend_slot;
                emit_item = rdata_r;
                emit_last = (pend_slot == occ_r);
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          case (cmd_r.command)
            bale_pkg::CMD_INS_FRONT: begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = cmd_r.value;
              occ_nxt = occ_r + CW'(1);
              emit    = 1'b1;
            end
            bale_pkg::CMD_RM_FRONT,
            bale_pkg::CMD_RM_AT: begin
              occ_nxt = occ_r - CW'(1);
              emit    = 1'b1;
            end
            bale_pkg::CMD_FIND: begin
              emit = 1'b1;
              if (hit_r) begin
                emit_slot = hit_slot_r;
              end else begin
                emit_st = bale_pkg::ST_NOTFOUND;
              end
            end
            bale_pkg::CMD_REPLACE: begin
              emit    = 1'b1;
              emit_st = hit_r ? bale_pkg::ST_OK : bale_pkg::ST_NOTFOUND;
            end
            bale_pkg::CMD_RM_VALUE: begin
              emit = 1'b1;
              if (hit_r) begin
                occ_nxt   = occ_r - CW'(1);
                emit_slot = hit_slot_r;
              end else begin
                emit_st = bale_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              // Dump has already delivered its last word.
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_left_r  <= rd_left_nxt;
    pend_idx_r <= pend_idx_nxt;
    down_r     <= down_nxt;
    hit_slot_r <= hit_slot_nxt;
    if (emit) begin
      out_data_r.status    <= emit_st;
      out_data_r.slot      <= emit_slot;
      out_data_r.item      <= emit_item;
      out_data_r.fill      <= occ_nxt;
      out_data_r.final_res <= emit_last;
    end
  end

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  // The fill count never passes the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(bale_pkg::CAPACITY))
    else $error("fill count exceeds capacity");

  // Read data is only pending inside a walk.
  a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_WALK))
    else $error("pending read outside a walk");

  // Nothing is written while the block waits for a command.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !we)
    else $error("element store written while idle");

  // A result word is only produced while the result register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result produced while result register is stalled");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top : self-checking testbench for the bounded array list engine
// A scripted table first walks the empty, full, not-found and bad-position
// cases at the value extremes. Random list traffic follows, with grow and
// shrink phases, random gaps and stalls on both channels, one long output
// hold-off and one drain pause. Every result word is compared with a
// typed-in word or a behavioral copy of the list kept inside the testbench.
// ============================================================================
module tb_top;
  import bale_pkg::*;

  localparam int RANDOM_ITEMS    = 290;
  localparam int QUIET_TAIL      = 40;
  localparam int HOLD_CYCLES     = 64;
  localparam int DRAIN_CYCLES    = 48;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int MAX_REPORTS     = 10;
  localparam int PAUSE_AT        = 150;
  localparam int HOLD_AT         = 10;

  // Command codes the block must drop without a result.
  localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;
  localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;

  // How each scripted word is checked: by the list model, against one
  // typed-in result word, or by the absence of any result.
  typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} chk_kind_e;

  typedef struct packed {
    in_word_t  cmd_word;
    int        reps;
    chk_kind_e chk;
    out_word_t known;
  } plan_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  // Behavioral copy of the list.
  logic [DATA_W-1:0] list_vals [CAPACITY];
  int                list_fill;

  plan_row_t script_rows [$];
  plan_row_t sent_rows [$];
  out_word_t model_words [$];
  out_word_t expected_words [$];

  logic [DATA_W-1:0] value_pool [4];
  logic [3:0] cmd_order [10] = '{CMD_INS_FRONT, CMD_INS_BACK, CMD_RM_FRONT,
                                 CMD_RM_BACK, CMD_RM_AT, CMD_FIND, CMD_REPLACE,
                                 CMD_RM_VALUE, CMD_DUMP, CMD_CLEAR};
  // Cumulative weights out of 100; whatever is left picks an unused code.
  int grow_mix   [10] = '{22, 46, 52, 58, 66, 76, 84, 92, 97, 98};
  int shrink_mix [10] = '{8, 16, 30, 44, 58, 68, 76, 88, 94, 96};

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  int mismatches    = 0;
  int cmds_accepted = 0;
  int words_checked = 0;
  int peak_fill     = 0;
  int idle_cycles   = 0;
  int status_seen [8];
  plan_row_t acc_row;
  bit progress;

  bounded_array_list_engine_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // List model
  // --------------------------------------------------------------------------
  function automatic void push_model_word(input logic [2:0] st, input int slot,
                                          input logic [DATA_W-1:0] item,
                                          input bit last);
    out_word_t r;
    r.status    = st;
    r.slot      = CNT_W'(slot);
    r.item      = item;
    r.fill      = CNT_W'(list_fill);
    r.final_res = last;
    model_words.push_back(r);
  endfunction

  // Closes the gap left by the element at 0-based index idx.
  function automatic void drop_entry(input int idx);
    int i;
    for (i = idx; i + 1 < list_fill; i++) list_vals[i] = list_vals[i + 1];
    list_fill--;
  endfunction

  // Applies one command word to the list copy and queues its result words.
  function automatic void predict_list_cmd(input in_word_t w);
    logic [2:0] st;
    int slot;
    int hits;
    int i;
    st   = ST_OK;
    slot = 0;
    hits = 0;
    case (w.command)
      CMD_CLEAR: list_fill = 0;
      CMD_INS_FRONT: begin
        if (list_fill >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          for (i = list_fill; i > 0; i--) list_vals[i] = list_vals[i - 1];
          list_vals[0] = w.value;
          list_fill++;
        end
      end
      CMD_INS_BACK: begin
        if (list_fill >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          list_vals[list_fill] = w.value;
          list_fill++;
        end
      end
      CMD_RM_FRONT: begin
        if (list_fill == 0) st = ST_EMPTY;
        else drop_entry(0);
      end
      CMD_RM_BACK: begin
        if (list_fill == 0) st = ST_EMPTY;
        else list_fill--;
      end
      CMD_RM_AT: begin
        // The empty check wins over the position check.
        if (list_fill == 0) st = ST_EMPTY;
        else if (w.position == 0 || w.position > list_fill) st = ST_BADPOS;
        else drop_entry(w.position - 1);
      end
      CMD_FIND: begin
        if (list_fill == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = 0; i < list_fill; i++) begin
            if (list_vals[i] == w.value) begin
              push_model_word(ST_OK, i + 1, w.value, 1'b0);
              hits++;
            end
          end
          if (hits == 0) st = ST_NOTFOUND;
          else model_words[model_words.size() - 1].final_res = 1'b1;
        end
      end
      CMD_REPLACE: begin
        for (i = 0; i < list_fill; i++) begin
          if (list_vals[i] == w.value) begin
            list_vals[i] = w.new_value;
            hits++;
          end
        end
        if (hits == 0) st = ST_NOTFOUND;
      end
      CMD_RM_VALUE: begin
        st = ST_NOTFOUND;
        for (i = 0; i < list_fill && st == ST_NOTFOUND; i++) begin
          if (list_vals[i] == w.value) begin
            drop_entry(i);
            st   = ST_OK;
            slot = i + 1;
          end
        end
      end
      CMD_DUMP: begin
        if (list_fill == 0) begin
          push_model_word(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < list_fill; i++)
            push_model_word(ST_OK, i + 1, list_vals[i], i + 1 == list_fill);
        end
      end
      default: ;
    endcase
    // Every command except a dump and a successful find gives exactly one
    // word carrying the command's own value; unused codes give none.
    if (w.command <= CMD_DUMP && w.command != CMD_DUMP && !(w.command == CMD_FIND
        && hits != 0))
      push_model_word(st, slot, w.value, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_row(input logic [3:0] cmd,
                                  input logic [DATA_W-1:0] val,
                                  input logic [DATA_W-1:0] nval,
                                  input logic [CNT_W-1:0] pos, input int reps,
                                  input chk_kind_e chk, input logic [2:0] st,
                                  input logic [DATA_W-1:0] item,
                                  input logic [CNT_W-1:0] fill);
    plan_row_t row;
    row.cmd_word.command   = cmd;
    row.cmd_word.value     = val;
    row.cmd_word.new_value = nval;
    row.cmd_word.position  = pos;
    row.reps               = reps;
    row.chk                = chk;
    row.known.status       = st;
    row.known.slot         = '0;
    row.known.item         = item;
    row.known.fill         = fill;
    row.known.final_res    = 1'b1;
    script_rows.push_back(row);
  endfunction

  // Mostly values from a small pool, so that finds and removals hit.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return value_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic in_word_t make_list_cmd(input bit grow);
    in_word_t w;
    int r;
    int i;
    bit picked;
    r         = $urandom_range(0, 99);
    picked    = 1'b0;
    w.command = CMD_FIRST_UNUSED +
                4'($urandom_range(0, CMD_LAST_UNUSED - CMD_FIRST_UNUSED));
    for (i = 0; i < 10; i++) begin
      if (!picked && r < (grow ? grow_mix[i] : shrink_mix[i])) begin
        w.command = cmd_order[i];
        picked    = 1'b1;
      end
    end
    w.value     = pick_value();
    w.new_value = pick_value();
    if (w.command == CMD_RM_AT && list_fill > 0 && $urandom_range(0, 4) != 0)
      w.position = CNT_W'($urandom_range(1, list_fill));
    else
      w.position = CNT_W'($urandom_range(0, CAPACITY));
    return w;
  endfunction

  // Entered and left at a falling edge. valid stays high after acceptance so
  // that a following word goes out without a dead cycle; release_input()
  // lowers it wherever the sender stops.
  task automatic drive_word(input plan_row_t row);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    sent_rows.push_back(row);
    in_valid <= 1'b1;
    in_data  <= row.cmd_word;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  function automatic void check_result(input out_word_t got);
    out_word_t want;
    status_seen[got.status]++;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $write("ERROR: result word with none expected: ");
        $display("st=%0d slot=%0d item=%h fill=%0d last=%0b",
                 got.status, got.slot, got.item, got.fill, got.final_res);
      end
    end else begin
      want = expected_words.pop_front();
      words_checked++;
      if (got.status !== want.status || got.slot !== want.slot ||
          got.item !== want.item || got.fill !== want.fill ||
          got.final_res !== want.final_res) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $write("ERROR: result %0d: exp st=%0d slot=%0d item=%h fill=%0d last=%0b, ",
                 words_checked, want.status, want.slot, want.item, want.fill,
                 want.final_res);
          $display("got st=%0d slot=%0d item=%h fill=%0d last=%0b",
                   got.status, got.slot, got.item, got.fill, got.final_res);
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: both channels are sampled at the rising edge. The list copy
  // advances as each command word is accepted, so expectations stay in order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      progress = 1'b0;
      if (in_valid && !in_stall) begin
        acc_row = sent_rows.pop_front();
        predict_list_cmd(in_data);
        case (acc_row.chk)
          CHK_MODEL: foreach (model_words[k]) expected_words.push_back(model_words[k]);
          CHK_ONE:   expected_words.push_back(acc_row.known);
          CHK_NONE:  ;
        endcase
        model_words.delete();
        cmds_accepted++;
        if (list_fill > peak_fill) peak_fill = list_fill;
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        check_result(out_data);
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("ERROR: no word moved for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_words.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and run control
  // --------------------------------------------------------------------------
  initial begin : list_traffic
    plan_row_t row;
    int real_items;
    int idle_chunk;
    bit paused;
    bit held;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    list_fill = 0;
    foreach (status_seen[s]) status_seen[s] = 0;
    value_pool[0] = '0;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = $urandom;
    value_pool[3] = $urandom;

    // Scripted part: empty-list errors, extremes, filling up, full errors,
    // then walks over a full list. Fill values in typed rows are exact.
    add_row(CMD_RM_FRONT, 32'd5, '0, 5'd1, 1, CHK_ONE, ST_EMPTY, 32'd5, 5'd0);
    add_row(CMD_RM_BACK, 32'hFFFF_FFFF, '0, 5'd0, 1, CHK_ONE, ST_EMPTY, 32'hFFFF_FFFF, 5'd0);
    add_row(CMD_RM_AT, 32'd7, '0, 5'd0, 1, CHK_ONE, ST_EMPTY, 32'd7, 5'd0);
    add_row(CMD_FIND, 32'd9, '0, 5'd0, 1, CHK_ONE, ST_EMPTY, 32'd9, 5'd0);
    add_row(CMD_DUMP, 32'h1234_5678, '0, 5'd0, 1, CHK_ONE, ST_EMPTY, 32'd0, 5'd0);
    add_row(CMD_REPLACE, 32'd3, 32'd4, 5'd0, 1, CHK_ONE, ST_NOTFOUND, 32'd3, 5'd0);
    add_row(CMD_RM_VALUE, 32'd3, '0, 5'd0, 1, CHK_ONE, ST_NOTFOUND, 32'd3, 5'd0);
    add_row(CMD_LAST_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1, CHK_NONE,
            ST_OK, '0, 5'd0);
    add_row(CMD_INS_BACK, 32'h7FFF_FFFF, '0, 5'd0, 1, CHK_ONE, ST_OK, 32'h7FFF_FFFF, 5'd1);
    add_row(CMD_INS_FRONT, 32'h8000_0000, '0, 5'd0, 1, CHK_ONE, ST_OK, 32'h8000_0000, 5'd2);
    add_row(CMD_RM_AT, 32'd1, '0, 5'd0, 1, CHK_ONE, ST_BADPOS, 32'd1, 5'd2);
    add_row(CMD_RM_AT, 32'd1, '0, 5'd16, 1, CHK_ONE, ST_BADPOS, 32'd1, 5'd2);
    add_row(CMD_INS_BACK, 32'h7FFF_FFFF, '0, 5'd0, CAPACITY - 2, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_INS_FRONT, 32'd1, '0, 5'd0, 1, CHK_ONE, ST_FULL, 32'd1, 5'd16);
    add_row(CMD_INS_BACK, 32'd2, '0, 5'd0, 1, CHK_ONE, ST_FULL, 32'd2, 5'd16);
    add_row(CMD_FIND, 32'h7FFF_FFFF, '0, 5'd0, 1, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_DUMP, '0, '0, 5'd0, 1, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_REPLACE, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_RM_AT, 32'd0, '0, 5'd16, 1, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_RM_VALUE, 32'h8000_0000, '0, 5'd0, 1, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_RM_FRONT, '0, '0, 5'd0, 1, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_RM_BACK, '0, '0, 5'd0, 1, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_FIRST_UNUSED, '0, '0, 5'd0, 1, CHK_NONE, ST_OK, '0, '0);
    add_row(CMD_DUMP, '0, '0, 5'd0, 1, CHK_MODEL, ST_OK, '0, '0);
    add_row(CMD_CLEAR, 32'd42, '0, 5'd0, 1, CHK_ONE, ST_OK, 32'd42, 5'd0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script_rows[r]) repeat (script_rows[r].reps) drive_word(script_rows[r]);

    // Random part: long grow phases alternate with shorter shrink phases so
    // that the list sweeps between empty and full.
    real_items = 0;
    idle_chunk = -1;
    paused     = 1'b0;
    held       = 1'b0;
    row.reps   = 1;
    row.chk    = CHK_MODEL;
    row.known  = '0;
    while (real_items < RANDOM_ITEMS) begin
      if (real_items >= RANDOM_ITEMS - QUIET_TAIL) begin
        idle_on = 1'b0;
      end else if (real_items / 40 != idle_chunk) begin
        idle_chunk = real_items / 40;
        idle_on    = ($urandom_range(0, 3) != 0);
      end
      if (real_items == HOLD_AT && !held) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (real_items == PAUSE_AT && !paused) begin
        // Let the block drain completely before the next word.
        paused = 1'b1;
        release_input();
        @(negedge clk);
        while (expected_words.size() != 0) @(negedge clk);
      end
      row.cmd_word = make_list_cmd((real_items / 30) % 3 != 2);
      drive_word(row);
      if (row.cmd_word.command <= CMD_DUMP) real_items++;
    end
    release_input();

    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    mismatches += expected_words.size();

    $display("Covered %0d command words (%0d scripted rows) and %0d result words;",
             cmds_accepted, script_rows.size(), words_checked);
    $display("peak fill %0d of %0d.", peak_fill, CAPACITY);
    $display("Statuses seen: ok %0d, full %0d, empty %0d, not found %0d, bad position %0d.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND], status_seen[ST_BADPOS]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
